// ===== rtl/core/rtdbg_pkg.sv =====
// rtdbg_pkg: shared types and constants of the ready-to-drive brake gate
`timescale 1ns / 1ps

package rtdbg_pkg;

  localparam int ADC_W    = 12;
  localparam int P_W      = 17;
  localparam int THR_W    = 16;
  localparam int ID_W     = 11;
  localparam int TENTHS_W = 12;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam int PROD_ADC_W = 24;
  localparam logic [PROD_ADC_W-1:0] ADC_GAIN   = 24'd2771;
  localparam logic signed [P_W-1:0] ADC_OFFSET = 17'sd4480;
  localparam int Q8_SHIFT = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_ID      = 1'b1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd256;
  localparam logic [ID_W-1:0]  MESSAGE_ID_RESET = 11'd20;

  typedef struct packed {
    logic             ignition_on;
    logic             button_event;
    logic [ADC_W-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic                       ignition_flag;
    logic                       ready_flag;
    logic signed [TENTHS_W-1:0] pressure_tenths;
    logic                       led_on;
    logic                       buzzer_pulse;
    logic                       ready_signal;
    logic [ID_W-1:0]            can_id;
  } out_item_t;

endpackage

// ===== rtl/core/rtdbg_if.sv =====
// rtdbg_in_if and rtdbg_out_if: valid/ready request channels of the brake gate
`timescale 1ns / 1ps

interface rtdbg_in_if;
  logic                valid;
  logic                ready;
  rtdbg_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtdbg_out_if;
  logic                 valid;
  logic                 ready;
  rtdbg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ready_to_drive_brake_gate_core.sv =====
// ready_to_drive_brake_gate_core: ready-to-drive mode machine with brake pressure averaging
//
// one request on in_chan is one pass of the control loop: ignition level,
// ready-button event and a raw 12-bit brake pressure sample. every request
// gives exactly one status request on out_chan, in order.
// the configuration port writes brake_threshold (index 0) or message_id
// (index 1) on any cycle with cfg_we high; write only while the block is idle.
// the result is registered through three register stages on its way to
// out_chan, the first loaded at the edge that accepts the request.
// throughput: one request per cycle while out_chan is not stalled; the three
// stages (pressure conversion, mode update with averaging, scaling to tenths
// of a bar) advance together. a stalled receiver freezes all stages and drops
// in_chan.ready for as long as a finished result waits on out_chan.
// reset (rst, synchronous) empties the pipe, puts the mode machine in init,
// lights the led, clears the status bytes and pressure history and restores
// the register defaults.
`timescale 1ns / 1ps

module ready_to_drive_brake_gate_core #(
  parameter int AVG_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  rtdbg_in_if.sink                             in_chan,
  rtdbg_out_if.source                          out_chan,
  input  logic                                 cfg_we,
  input  logic [rtdbg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtdbg_pkg::CFG_W-1:0]          cfg_data
);

  localparam int P_W     = rtdbg_pkg::P_W;
  localparam int HIST_N  = AVG_DEPTH - 1;
  localparam int SUM_W   = P_W + $clog2(AVG_DEPTH);
  localparam int PROD_W  = SUM_W + 4;
  localparam int MAG_W   = PROD_W - rtdbg_pkg::Q8_SHIFT;
  localparam int RSHIFT  = MAG_W + $clog2(AVG_DEPTH);
  localparam int RECIP_W = RSHIFT + 1;
  localparam int QP_W    = MAG_W + RECIP_W;
  localparam int T_W     = rtdbg_pkg::TENTHS_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RSHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);

  typedef enum logic [1:0] {
    MODE_INIT    = 2'd0,
    MODE_WAITING = 2'd1,
    MODE_BUZZING = 2'd2,
    MODE_READY   = 2'd3
  } mode_t;

  typedef struct packed {
    logic                     ignition_flag;
    logic                     ready_flag;
    logic                     led_on;
    logic                     buzzer_pulse;
    logic                     ready_signal;
    logic [rtdbg_pkg::ID_W-1:0] can_id;
    logic                     neg;
    logic [MAG_W-1:0]         mag;
  } mid_t;

  // configuration
  logic [rtdbg_pkg::THR_W-1:0] brake_threshold;
  logic [rtdbg_pkg::ID_W-1:0]  message_id;

  // pipeline control
  logic advance;
  logic v1, v2, v3;

  // stage one
  logic                  s1_ign;
  logic                  s1_btn;
  logic signed [P_W-1:0] s1_p;
  logic [rtdbg_pkg::PROD_ADC_W-1:0] adc_prod;
  logic signed [P_W-1:0] p_in;

  // mode machine state
  mode_t mode, mode_next;
  logic  ignition_byte, ignition_byte_next;
  logic  ready_byte, ready_byte_next;
  logic  led_state, led_state_next;
  logic  buzz, rsig;
  logic signed [P_W-1:0] hist [HIST_N];

  // averaging
  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] sum10;
  logic        [PROD_W-1:0] sum10_abs;
  logic                     pass_thr;

  // stage two and three
  mid_t                 s2;
  logic [QP_W-1:0]      q_full;
  logic [T_W-1:0]       q;
  rtdbg_pkg::out_item_t out_data;

  assign advance       = !v3 || out_chan.ready;
  assign in_chan.ready = advance;
  assign out_chan.valid = v3;
  assign out_chan.data  = out_data;

  // q8 bar conversion
  assign adc_prod = {{(rtdbg_pkg::PROD_ADC_W-rtdbg_pkg::ADC_W){1'b0}},
                     in_chan.data.adc_sample} * rtdbg_pkg::ADC_GAIN;
  assign p_in = signed'({1'b0, adc_prod[rtdbg_pkg::PROD_ADC_W-1:rtdbg_pkg::Q8_SHIFT]})
                - rtdbg_pkg::ADC_OFFSET;

  assign pass_thr = s1_p >= signed'({1'b0, brake_threshold});

  always_comb begin
    mode_next          = mode;
    ignition_byte_next = ignition_byte;
    ready_byte_next    = ready_byte;
    led_state_next     = led_state;
    buzz               = 1'b0;
    rsig               = 1'b0;
    unique case (mode)
      MODE_INIT: begin
        ignition_byte_next = 1'b0;
        mode_next          = MODE_WAITING;
      end
      MODE_WAITING: begin
        led_state_next  = 1'b0;
        ready_byte_next = 1'b0;
        if (s1_ign) begin
          ignition_byte_next = 1'b1;
          if (s1_btn && pass_thr) begin
            mode_next = MODE_BUZZING;
          end
        end else begin
          mode_next = MODE_INIT;
        end
      end
      MODE_BUZZING: begin
        led_state_next = 1'b1;
        buzz           = 1'b1;
        mode_next      = MODE_READY;
      end
      MODE_READY: begin
        if (s1_ign) begin
          ignition_byte_next = 1'b1;
          ready_byte_next    = 1'b1;
          rsig               = 1'b1;
        end else begin
          ignition_byte_next = 1'b0;
          ready_byte_next    = 1'b0;
          mode_next          = MODE_WAITING;
        end
      end
      default: begin
        mode_next = MODE_INIT;
      end
    endcase
  end

  // current sample counted once, then scaled by ten
  always_comb begin
    sum = SUM_W'(s1_p);
    for (int i = 0; i < HIST_N; i++) begin
      sum = sum + SUM_W'(hist[i]);
    end
    sum10     = (PROD_W'(sum) <<< 3) + (PROD_W'(sum) <<< 1);
    sum10_abs = sum10[PROD_W-1] ? PROD_W'(-sum10) : PROD_W'(sum10);
  end

  // divide by the averaging depth (AVG_DEPTH) through a reciprocal
  assign q_full = {{RECIP_W{1'b0}}, s2.mag} * {{MAG_W{1'b0}}, RECIP};
  assign q      = q_full[RSHIFT +: T_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_threshold <= rtdbg_pkg::THRESHOLD_RESET;
      message_id      <= rtdbg_pkg::MESSAGE_ID_RESET;
      v1              <= 1'b0;
      v2              <= 1'b0;
      v3              <= 1'b0;
      mode            <= MODE_INIT;
      ignition_byte   <= 1'b0;
      ready_byte      <= 1'b0;
      led_state       <= 1'b1;
      for (int i = 0; i < HIST_N; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rtdbg_pkg::CFG_BRAKE_THRESHOLD: brake_threshold <= cfg_data;
          rtdbg_pkg::CFG_MESSAGE_ID:      message_id <= cfg_data[rtdbg_pkg::ID_W-1:0];
          default: begin
          end
        endcase
      end
      if (advance) begin
        v1 <= in_chan.valid;
        v2 <= v1;
        v3 <= v2;
        if (v1) begin
          mode          <= mode_next;
          ignition_byte <= ignition_byte_next;
          ready_byte    <= ready_byte_next;
          led_state     <= led_state_next;
          hist[0]       <= s1_p;
          for (int i = 1; i < HIST_N; i++) begin
            hist[i] <= hist[i-1];
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ign <= in_chan.data.ignition_on;
      s1_btn <= in_chan.data.button_event;
      s1_p   <= p_in;

      s2.ignition_flag <= ignition_byte_next;
      s2.ready_flag    <= ready_byte_next;
      s2.led_on        <= led_state_next;
      s2.buzzer_pulse  <= buzz;
      s2.ready_signal  <= rsig;
      s2.can_id        <= message_id;
      s2.neg           <= sum10[PROD_W-1];
      s2.mag           <= sum10_abs[PROD_W-1:rtdbg_pkg::Q8_SHIFT];

      out_data.ignition_flag   <= s2.ignition_flag;
      out_data.ready_flag      <= s2.ready_flag;
      out_data.pressure_tenths <= s2.neg ? signed'(T_W'(-q)) : signed'(q);
      out_data.led_on          <= s2.led_on;
      out_data.buzzer_pulse    <= s2.buzzer_pulse;
      out_data.ready_signal    <= s2.ready_signal;
      out_data.can_id          <= s2.can_id;
    end
  end

endmodule
